[src/lct_pkg.sv]
// lct_pkg: shared types for the LFU cache table.
// Used by lct_cell and lfu_cache_table; no dependencies.
`default_nettype none
package lct_pkg;

  localparam int COUNT_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_PICK,
    ST_UPD
  } state_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic upd;   // shift positions 0..upd_pos, load new entry at the front
    logic clr;   // clear victim candidate
    logic scan;  // advance victim candidate one cell
  } cell_ctl_t;

endpackage
`default_nettype wire

[src/lct_cell.sv]
// lct_cell: one slot of the recency-ordered entry chain plus one stage of the
// victim search chain. Depends on lct_pkg.
`default_nettype none
module lct_cell #(
  parameter int KW    = 32,
  parameter int VW    = 32,
  parameter int POS_W = 4,
  parameter int IDX   = 0
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  lct_pkg::cell_ctl_t          ctl,
  input  wire [POS_W-1:0]             upd_pos,
  input  wire [KW-1:0]                new_key,
  input  wire [VW-1:0]                new_value,
  input  wire [lct_pkg::COUNT_W-1:0]  new_count,
  input  wire                         prev_valid,
  input  wire [KW-1:0]                prev_key,
  input  wire [VW-1:0]                prev_value,
  input  wire [lct_pkg::COUNT_W-1:0]  prev_count,
  input  wire                         prev_cand_valid,
  input  wire [lct_pkg::COUNT_W-1:0]  prev_cand_count,
  input  wire [POS_W-1:0]             prev_cand_pos,
  input  wire [KW-1:0]                prev_cand_key,
  input  wire [KW-1:0]                look_key,
  output logic                        valid,
  output logic [KW-1:0]               key,
  output logic [VW-1:0]               value,
  output logic [lct_pkg::COUNT_W-1:0] count,
  output logic                        cand_valid,
  output logic [lct_pkg::COUNT_W-1:0] cand_count,
  output logic [POS_W-1:0]            cand_pos,
  output logic [KW-1:0]               cand_key,
  output logic                        match
);

  logic                        valid_r, valid_nxt;
  logic [KW-1:0]               key_r, key_nxt;
  logic [VW-1:0]               value_r, value_nxt;
  logic [lct_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                        cv_r, cv_nxt;
  logic [lct_pkg::COUNT_W-1:0] cc_r, cc_nxt;
  logic [POS_W-1:0]            cp_r, cp_nxt;
  logic [KW-1:0]               ck_r, ck_nxt;
  logic                        take_own;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    count_nxt = count_r;
    if (ctl.upd && (POS_W'(IDX) <= upd_pos)) begin
      if (IDX == 0) begin
        valid_nxt = 1'b1;
        key_nxt   = new_key;
        value_nxt = new_value;
        count_nxt = new_count;
      end else begin
        valid_nxt = prev_valid;
        key_nxt   = prev_key;
        value_nxt = prev_value;
        count_nxt = prev_count;
      end
    end
  end

  // later position is less recent, so it wins a tie
  assign take_own = valid_r && (!prev_cand_valid || (count_r <= prev_cand_count));

  always_comb begin
    cv_nxt = cv_r;
    cc_nxt = cc_r;
    cp_nxt = cp_r;
    ck_nxt = ck_r;
    if (ctl.clr) begin
      cv_nxt = 1'b0;
    end else if (ctl.scan) begin
      if (take_own) begin
        cv_nxt = 1'b1;
        cc_nxt = count_r;
        cp_nxt = POS_W'(IDX);
        ck_nxt = key_r;
      end else begin
        cv_nxt = prev_cand_valid;
        cc_nxt = prev_cand_count;
        cp_nxt = prev_cand_pos;
        ck_nxt = prev_cand_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cv_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      cv_r    <= cv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    count_r <= count_nxt;
    cc_r    <= cc_nxt;
    cp_r    <= cp_nxt;
    ck_r    <= ck_nxt;
  end

  assign valid      = valid_r;
  assign key        = key_r;
  assign value      = value_r;
  assign count      = count_r;
  assign cand_valid = cv_r;
  assign cand_count = cc_r;
  assign cand_pos   = cp_r;
  assign cand_key   = ck_r;
  assign match      = valid_r && (key_r == look_key);

endmodule
`default_nettype wire

[src/lfu_cache_table.sv]
// lfu_cache_table: LFU key/value cache with LRU tie break, built as a chain
// of lct_cell slots kept in recency order. Depends on lct_pkg, lct_cell.
//
// Input channel in_*: one get or set per transfer; tdata = key, value;
// tuser = action (0 get, 1 set). Output channel out_*: one result per item;
// tdata = read_value, evicted_key; tuser = hit, evicted.
// Config channel cfg_*: capacity write, always ready; write only when idle.
// Flow: an item is taken in idle, then a parallel key match (LOOK), then
// an update state that shifts the chain and loads the output register.
// A hit, a get or a set with free room goes from the match straight to the
// update. A set on a new key with the cache full first runs the victim
// search along the cell chain (SCAN, then PICK) before the update. A new
// item is taken only in idle, so one item is in flight at a time.
// The output register holds a result until taken; the next item is accepted
// meanwhile, and its update stalls only if the previous result is still
// waiting. Reset empties the cache and sets capacity to 16; no clearing pass.
`default_nettype none
module lfu_cache_table #(
  parameter int ENTRIES     = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32,
  localparam int IN_DW      = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW     = ((VALUE_WIDTH + KEY_WIDTH + 7) / 8) * 8
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire [IN_DW-1:0]   in_tdata,   // key, value
  input  wire               in_tuser,   // action
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // read_value, evicted_key
  output logic [1:0]        out_tuser,  // hit, evicted
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [4:0]         cfg_data
);

  localparam int KW    = KEY_WIDTH;
  localparam int VW    = VALUE_WIDTH;
  localparam int CW    = lct_pkg::COUNT_W;
  localparam int POS_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);

  lct_pkg::state_t    state_r, state_nxt;
  lct_pkg::cell_ctl_t ctl;

  logic [4:0]       cap_r;
  logic [OCC_W-1:0] occ_r;
  logic [POS_W-1:0] scnt_r;
  logic             act_r;
  logic [KW-1:0]    key_r;
  logic [VW-1:0]    val_r;
  logic             hit_r;
  logic [POS_W-1:0] pos_r;
  logic [VW-1:0]    nval_r;
  logic [CW-1:0]    ncnt_r;
  logic             ev_r;
  logic [KW-1:0]    evkey_r;
  logic             ov_r;
  logic [OUT_DW-1:0] od_r;
  logic [1:0]       ou_r;

  logic             c_vld [ENTRIES];
  logic [KW-1:0]    c_key [ENTRIES];
  logic [VW-1:0]    c_val [ENTRIES];
  logic [CW-1:0]    c_cnt [ENTRIES];
  logic             d_vld [ENTRIES];
  logic [CW-1:0]    d_cnt [ENTRIES];
  logic [POS_W-1:0] d_pos [ENTRIES];
  logic [KW-1:0]    d_key [ENTRIES];
  logic [ENTRIES-1:0] m;

  logic             any_hit, need_evict, out_free, take_in;
  logic [POS_W-1:0] hpos;
  logic [VW-1:0]    hval;
  logic [CW-1:0]    hcnt;
  logic [8:0]       cap_eff;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
        lct_cell #(.KW(KW), .VW(VW), .POS_W(POS_W), .IDX(g)) u_cell (
          .clk, .rst_n, .ctl, .upd_pos(pos_r),
          .new_key(key_r), .new_value(nval_r), .new_count(ncnt_r),
          .prev_valid(1'b0), .prev_key('0), .prev_value('0), .prev_count('0),
          .prev_cand_valid(1'b0), .prev_cand_count('0), .prev_cand_pos('0),
          .prev_cand_key('0), .look_key(key_r),
          .valid(c_vld[g]), .key(c_key[g]), .value(c_val[g]), .count(c_cnt[g]),
          .cand_valid(d_vld[g]), .cand_count(d_cnt[g]), .cand_pos(d_pos[g]),
          .cand_key(d_key[g]), .match(m[g])
        );
      end else begin : g_body
        lct_cell #(.KW(KW), .VW(VW), .POS_W(POS_W), .IDX(g)) u_cell (
          .clk, .rst_n, .ctl, .upd_pos(pos_r),
          .new_key(key_r), .new_value(nval_r), .new_count(ncnt_r),
          .prev_valid(c_vld[g-1]), .prev_key(c_key[g-1]),
          .prev_value(c_val[g-1]), .prev_count(c_cnt[g-1]),
          .prev_cand_valid(d_vld[g-1]), .prev_cand_count(d_cnt[g-1]),
          .prev_cand_pos(d_pos[g-1]), .prev_cand_key(d_key[g-1]),
          .look_key(key_r),
          .valid(c_vld[g]), .key(c_key[g]), .value(c_val[g]), .count(c_cnt[g]),
          .cand_valid(d_vld[g]), .cand_count(d_cnt[g]), .cand_pos(d_pos[g]),
          .cand_key(d_key[g]), .match(m[g])
        );
      end
    end
  endgenerate

  // at most one cell matches
  always_comb begin
    hpos = '0;
    hval = '0;
    hcnt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (m[i]) begin
        hpos = hpos | POS_W'(i);
        hval = hval | c_val[i];
        hcnt = hcnt | c_cnt[i];
      end
    end
  end

  always_comb begin
    cap_eff = {4'b0000, cap_r};
    if (cap_eff == 9'd0) cap_eff = 9'd1;
    if (cap_eff > 9'(ENTRIES)) cap_eff = 9'(ENTRIES);
  end

  assign any_hit    = |m;
  assign need_evict = !any_hit && act_r && (9'(occ_r) >= cap_eff);
  assign out_free   = !ov_r || out_tready;
  assign take_in    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lct_pkg::ST_IDLE: if (take_in) state_nxt = lct_pkg::ST_LOOK;
      lct_pkg::ST_LOOK: state_nxt = need_evict ? lct_pkg::ST_SCAN : lct_pkg::ST_UPD;
      lct_pkg::ST_SCAN: if (scnt_r == POS_W'(ENTRIES - 1)) state_nxt = lct_pkg::ST_PICK;
      lct_pkg::ST_PICK: state_nxt = lct_pkg::ST_UPD;
      lct_pkg::ST_UPD:  if (out_free) state_nxt = lct_pkg::ST_IDLE;
      default:          state_nxt = lct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == lct_pkg::ST_IDLE);
    ctl.clr   = (state_r == lct_pkg::ST_LOOK);
    ctl.scan  = (state_r == lct_pkg::ST_SCAN);
    ctl.upd   = (state_r == lct_pkg::ST_UPD) && out_free && (hit_r || act_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lct_pkg::ST_IDLE;
      cap_r   <= 5'd16;
      occ_r   <= '0;
      scnt_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) cap_r <= cfg_data;
      if (state_r == lct_pkg::ST_LOOK) scnt_r <= '0;
      else if (state_r == lct_pkg::ST_SCAN) scnt_r <= scnt_r + 1'b1;
      if (state_r == lct_pkg::ST_UPD && out_free) begin
        ov_r <= 1'b1;
        if (!hit_r && act_r && !ev_r) occ_r <= occ_r + 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      act_r <= in_tuser;
      key_r <= in_tdata[KW-1:0];
      val_r <= in_tdata[KW+VW-1:KW];
    end
    if (state_r == lct_pkg::ST_LOOK) begin
      hit_r <= any_hit;
      ev_r  <= 1'b0;
      if (any_hit) begin
        pos_r  <= hpos;
        nval_r <= act_r ? val_r : hval;
        ncnt_r <= (hcnt == {CW{1'b1}}) ? hcnt : hcnt + 1'b1;
      end else begin
        pos_r  <= occ_r[POS_W-1:0];
        nval_r <= val_r;
        ncnt_r <= CW'(1);
      end
    end
    if (state_r == lct_pkg::ST_PICK) begin
      ev_r    <= d_vld[ENTRIES-1];
      pos_r   <= d_pos[ENTRIES-1];
      evkey_r <= d_key[ENTRIES-1];
    end
    if (state_r == lct_pkg::ST_UPD && out_free) begin
      od_r <= OUT_DW'({(ev_r ? evkey_r : {KW{1'b0}}),
                       ((hit_r && !act_r) ? nval_r : {VW{1'b0}})});
      ou_r <= {ev_r, hit_r};
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

endmodule
`default_nettype wire

[verif/lfu_cache_table_test.sv]
// lfu_cache_table_test: self-checking bench for lfu_cache_table.
// Drives gets and sets, predicts each result with a behavioural LFU/LRU
// model and compares per field. Depends on lct_pkg and lfu_cache_table.
`timescale 1ns / 100ps
module lfu_cache_table_test;

  localparam int NSLOT = 16;
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } result_t;

  typedef struct {
    logic        act;
    logic [31:0] key;
    logic [31:0] val;
    logic        chk;
    result_t     res;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [4:0] cfg_data = '0;

  always #4 clk = ~clk;

  lfu_cache_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // cache shadow
  logic [4:0]  cap_reg;
  logic        c_valid [NSLOT];
  logic [31:0] c_key [NSLOT];
  logic [31:0] c_val [NSLOT];
  logic [31:0] c_uses [NSLOT];
  logic [4:0]  c_rank [NSLOT];
  int          c_fill;

  result_t pending_results[$];
  int errors = 0;
  int wdog = 0;
  bit quiet = 1'b0;
  bit [31:0] key_pool [8];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void bump_slot(int s);
    for (int i = 0; i < NSLOT; i++)
      if (c_valid[i] && i != s && c_rank[i] < c_rank[s]) c_rank[i]++;
    c_rank[s] = '0;
    if (c_uses[s] != 32'hFFFF_FFFF) c_uses[s]++;
  endfunction

  function automatic result_t cache_access(logic act, logic [31:0] key, logic [31:0] val);
    result_t r;
    int lim, slot, victim;
    bit have;
    r = '0;
    lim = (cap_reg < 5'd1) ? 1 : (int'(cap_reg) > NSLOT) ? NSLOT : int'(cap_reg);
    slot = -1;
    for (int i = 0; i < NSLOT; i++)
      if (slot < 0 && c_valid[i] && c_key[i] == key) slot = i;
    if (slot >= 0) begin
      r.hit = 1'b1;
      bump_slot(slot);
      if (act == ACT_SET) c_val[slot] = val;
      else r.read_value = c_val[slot];
      return r;
    end
    if (act == ACT_GET) return r;
    if (c_fill >= lim) begin
      have = 1'b0;
      victim = 0;
      for (int i = 0; i < NSLOT; i++) begin
        if (!c_valid[i]) continue;
        if (!have || c_uses[i] < c_uses[victim] ||
            (c_uses[i] == c_uses[victim] && c_rank[i] > c_rank[victim])) begin
          victim = i;
          have = 1'b1;
        end
      end
      if (have) begin
        for (int i = 0; i < NSLOT; i++)
          if (c_valid[i] && c_rank[i] > c_rank[victim]) c_rank[i]--;
        c_valid[victim] = 1'b0;
        c_fill--;
        r.evicted = 1'b1;
        r.evicted_key = c_key[victim];
      end
    end
    slot = -1;
    for (int i = 0; i < NSLOT; i++)
      if (slot < 0 && !c_valid[i]) slot = i;
    for (int i = 0; i < NSLOT; i++)
      if (c_valid[i]) c_rank[i]++;
    c_valid[slot] = 1'b1;
    c_key[slot] = key;
    c_val[slot] = val;
    c_uses[slot] = 32'd1;
    c_rank[slot] = '0;
    c_fill++;
    return r;
  endfunction

  task automatic idle_burst();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  task automatic send_item(logic act, logic [31:0] key, logic [31:0] val,
                           logic chk, result_t want);
    result_t p;
    idle_burst();
    p = cache_access(act, key, val);
    if (chk && p != want) begin
      $display("directed row disagrees with prediction for key %h", key);
      errors++;
    end
    pending_results.push_back(p);
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {val, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_capacity(logic [4:0] c);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_reg = c;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
      end else begin
        result_t w;
        w = pending_results.pop_front();
        if (out_tuser[0] !== w.hit)
          report_mismatch("hit", 32'(out_tuser[0]), 32'(w.hit));
        if (out_tuser[1] !== w.evicted)
          report_mismatch("evicted", 32'(out_tuser[1]), 32'(w.evicted));
        if (out_tdata[31:0] !== w.read_value)
          report_mismatch("read_value", out_tdata[31:0], w.read_value);
        if (out_tdata[63:32] !== w.evicted_key)
          report_mismatch("evicted_key", out_tdata[63:32], w.evicted_key);
      end
    end
  end

  always @(negedge clk) begin
    if (quiet || $urandom_range(0, 5) != 0) out_tready <= 1'b1;
    else begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 14) - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      wdog <= 0;
    else if (rst_n) wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  stim_t rows[$];

  function automatic stim_t row(logic a, logic [31:0] k, logic [31:0] v, int c,
                                int h, logic [31:0] rv, int e, logic [31:0] ek);
    stim_t s;
    s.act = a; s.key = k; s.val = v; s.chk = (c != 0);
    s.res = '{hit: (h != 0), read_value: rv, evicted: (e != 0), evicted_key: ek};
    return s;
  endfunction

  task automatic random_phase(int n, int keys);
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, keys - 1)];
      send_item(1'($urandom_range(0, 1)), k, $urandom(), 1'b0, '0);
    end
  endtask

  initial begin
    cap_reg = 5'd16;
    c_fill = 0;
    for (int i = 0; i < NSLOT; i++) begin
      c_valid[i] = 1'b0; c_key[i] = '0; c_val[i] = '0; c_uses[i] = '0; c_rank[i] = '0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty cache, extremes, capacity one
    rows.push_back(row(ACT_GET, 32'h0, 32'h0, 1, 0, 0, 0, 0));
    rows.push_back(row(ACT_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 0, 0));
    rows.push_back(row(ACT_GET, 32'hFFFF_FFFF, 32'h0, 1, 1, 32'hFFFF_FFFF, 0, 0));
    rows.push_back(row(ACT_SET, 32'hFFFF_FFFF, 32'h1234_5678, 1, 1, 0, 0, 0));
    rows.push_back(row(ACT_SET, 32'h0, 32'h0, 1, 0, 0, 0, 0));
    rows.push_back(row(ACT_GET, 32'h0, 32'hFFFF_FFFF, 1, 1, 0, 0, 0));
    rows.push_back(row(ACT_GET, 32'hFFFF_FFFF, 32'h0, 1, 1, 32'h1234_5678, 0, 0));
    foreach (rows[i]) send_item(rows[i].act, rows[i].key, rows[i].val, rows[i].chk, rows[i].res);
    rows.delete();

    // lowered below occupancy: one eviction per new key
    set_capacity(5'd1);
    rows.push_back(row(ACT_SET, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1, 0, 0, 1, 32'h0));
    rows.push_back(row(ACT_SET, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 0, 0, 0, 0, 0));
    rows.push_back(row(ACT_GET, 32'hA5A5_A5A5, 32'h0, 0, 0, 0, 0, 0));
    foreach (rows[i]) send_item(rows[i].act, rows[i].key, rows[i].val, rows[i].chk, rows[i].res);
    rows.delete();

    set_capacity(5'd0);
    rows.push_back(row(ACT_SET, 32'h1, 32'h11, 0, 0, 0, 0, 0));
    rows.push_back(row(ACT_SET, 32'h2, 32'h22, 0, 0, 0, 0, 0));
    rows.push_back(row(ACT_GET, 32'h2, 32'h0, 1, 1, 32'h22, 0, 0));
    foreach (rows[i]) send_item(rows[i].act, rows[i].key, rows[i].val, rows[i].chk, rows[i].res);
    rows.delete();

    // above the table size, then tie breaks at three
    set_capacity(5'd31);
    for (int i = 0; i < 18; i++) send_item(ACT_SET, 32'h100 + i, i, 1'b0, '0);
    set_capacity(5'd3);
    send_item(ACT_SET, 32'h200, 32'd1, 1'b0, '0);

    for (int ph = 0; ph < 6; ph++) begin
      set_capacity(5'($urandom_range(0, 31)));
      foreach (key_pool[i]) key_pool[i] = $urandom();
      random_phase(150, $urandom_range(2, 8));
    end
    set_capacity(5'd16);
    foreach (key_pool[i]) key_pool[i] = $urandom();
    quiet = 1'b1;
    random_phase(100, 8);

    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
